// ----- design/ksn_pkg.sv -----
// ksn_pkg: shared types and constants for the k-smallest node selector.
// Used by ksn_ctrl, ksn_datapath and the top level; depends on nothing.
package ksn_pkg;

  // Fixed field widths
  localparam int CFG_W     = 7;   // keep_count width, widest register
  localparam int CFG_IDX_W = 1;   // two configuration registers
  localparam int ID_W      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 1'b1;

  // Reset values
  localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 7'd1;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // accept one input transaction
    logic rst_pos;   // clear the emission position counter
    logic arr_read;  // read arrival memory at the position counter
    logic step;      // advance the position counter
    logic shift;     // shift the kept id chain up by one cell
    logic clear;     // drop the list after the final result
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic arr_mode;    // list short enough: return ids in arrival order
    logic list_empty;  // selection holds no entry
    logic align_done;  // largest kept id sits in the top cell
    logic last_out;    // the result on display is the last of the run
  } dp_status_t;

endpackage

// ----- design/ksn_ctrl.sv -----
// ksn_ctrl: controller state machine for the k-smallest node selector.
// Depends on ksn_pkg (command and status structs).
module ksn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last_entry,
  input  logic                 out_stall,
  input  ksn_pkg::dp_status_t  sts,
  output ksn_pkg::dp_cmd_t     cmd,
  output logic                 in_stall,
  output logic                 out_valid,
  output logic                 out_empty_list,
  output logic                 out_last_result
);
  import ksn_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DECIDE,
    ST_ARR_RD,
    ST_ARR_OUT,
    ST_ALIGN,
    ST_KEPT_OUT,
    ST_EMPTY_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall_r;
  assign out_acc = out_valid_r && !out_stall;

  // Next state, registered outputs and datapath commands
  always_comb begin
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load = in_acc;
        if (in_acc && in_last_entry) begin
          state_nxt    = ST_DECIDE;
          in_stall_nxt = 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd.rst_pos = 1'b1;
        if (sts.list_empty) begin
          state_nxt     = ST_EMPTY_OUT;
          out_valid_nxt = 1'b1;
        end else if (sts.arr_mode) begin
          state_nxt = ST_ARR_RD;
        end else begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ARR_RD: begin
        cmd.arr_read  = 1'b1;
        state_nxt     = ST_ARR_OUT;
        out_valid_nxt = 1'b1;
      end
      ST_ARR_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (sts.last_out) begin
            cmd.clear    = 1'b1;
            state_nxt    = ST_LOAD;
            in_stall_nxt = 1'b0;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = ST_ARR_RD;
          end
        end
      end
      ST_ALIGN: begin
        if (sts.align_done) begin
          state_nxt     = ST_KEPT_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          cmd.step  = 1'b1;
          cmd.shift = 1'b1;
        end
      end
      ST_KEPT_OUT: begin
        if (out_acc) begin
          if (sts.last_out) begin
            cmd.clear     = 1'b1;
            state_nxt     = ST_LOAD;
            in_stall_nxt  = 1'b0;
            out_valid_nxt = 1'b0;
          end else begin
            cmd.step  = 1'b1;
            cmd.shift = 1'b1;
          end
        end
      end
      ST_EMPTY_OUT: begin
        if (out_acc) begin
          cmd.clear     = 1'b1;
          state_nxt     = ST_LOAD;
          in_stall_nxt  = 1'b0;
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt     = ST_LOAD;
        in_stall_nxt  = 1'b0;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall        = in_stall_r;
  assign out_valid       = out_valid_r;
  assign out_empty_list  = (state_r == ST_EMPTY_OUT);
  assign out_last_result = (state_r == ST_EMPTY_OUT) || sts.last_out;

endmodule

// ----- design/ksn_datapath.sv -----
// ksn_datapath: configuration registers, arrival id memory, sorted insertion
// chain and emission counter. Depends on ksn_pkg.
module ksn_datapath #(
  parameter int MAX_NODES  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ksn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ksn_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [ksn_pkg::ID_W-1:0]             in_node_id,
  input  logic                                 in_present,
  input  logic signed [VALUE_BITS-1:0]         in_node_value,
  input  ksn_pkg::dp_cmd_t                     cmd,
  output ksn_pkg::dp_status_t                  sts,
  output logic [ksn_pkg::ID_W-1:0]             out_node_id
);
  import ksn_pkg::*;

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

  // Configuration
  logic [CFG_W-1:0] keep_count_r;
  logic             select_mode_r;

  // List state
  logic [CNT_W-1:0] counted_r;
  logic [CNT_W-1:0] kept_cnt_r, kept_cnt_nxt;
  logic [CNT_W-1:0] pos_r;
  logic [ID_W-1:0]  arr_mem [MAX_NODES];
  logic [ID_W-1:0]  rd_id_r;

  // Insertion chain cells, ascending by value
  logic signed [VALUE_BITS-1:0] vals_r   [MAX_NODES];
  logic signed [VALUE_BITS-1:0] vals_nxt [MAX_NODES];
  logic [ID_W-1:0]              ids_r    [MAX_NODES];
  logic [ID_W-1:0]              ids_nxt  [MAX_NODES];

  logic [CNT_W-1:0]     k_eff, k_m1, kc_t, m_sel;
  logic [MAX_NODES-1:0] le;
  logic                 counts, eligible, do_count, do_ins, ins_ok;
  logic [CNT_W:0]       align_sum, arr_next;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r  <= KEEP_COUNT_RST;
      select_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEEP_COUNT:  keep_count_r  <= cfg_wdata;
        REG_SELECT_MODE: select_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective k, trimmed kept count and entry classification
  assign k_eff = (keep_count_r > CFG_W'(MAX_NODES)) ? MAX_CNT : CNT_W'(keep_count_r);
  assign k_m1  = k_eff - 1'b1;
  assign kc_t  = (kept_cnt_r > k_eff) ? k_eff : kept_cnt_r;
  assign m_sel = kc_t;

  assign counts   = select_mode_r ? in_present : 1'b1;
  assign eligible = select_mode_r ? 1'b1
                  : ((in_node_id != '0) && in_present && !in_node_value[VALUE_BITS-1]);
  assign do_count = cmd.load && counts && (counted_r < MAX_CNT);
  assign do_ins   = do_count && eligible && (k_eff != '0);

  // Parallel compare: thermometer of cells that rank at or below the new key
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      le[i] = (CNT_W'(i) < kc_t) && (vals_r[i] <= in_node_value);
    end
  end

  assign ins_ok = !le[k_m1[IDX_W-1:0]];

  // Chain update: insert with shift, or shift ids up during emission
  always_comb begin
    vals_nxt     = vals_r;
    ids_nxt      = ids_r;
    kept_cnt_nxt = kept_cnt_r;
    if (do_ins) begin
      kept_cnt_nxt = kc_t;
      if (ins_ok) begin
        if (kc_t < k_eff) kept_cnt_nxt = kc_t + 1'b1;
        if (!le[0]) begin
          vals_nxt[0] = in_node_value;
          ids_nxt[0]  = in_node_id;
        end
        for (int i = 1; i < MAX_NODES; i++) begin
          if (!le[i]) begin
            if (le[i-1]) begin
              vals_nxt[i] = in_node_value;
              ids_nxt[i]  = in_node_id;
            end else begin
              vals_nxt[i] = vals_r[i-1];
              ids_nxt[i]  = ids_r[i-1];
            end
          end
        end
      end
    end else if (cmd.shift) begin
      for (int i = 1; i < MAX_NODES; i++) begin
        ids_nxt[i] = ids_r[i-1];
      end
    end
    if (cmd.clear) kept_cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    vals_r <= vals_nxt;
    ids_r  <= ids_nxt;
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counted_r  <= '0;
      kept_cnt_r <= '0;
      pos_r      <= '0;
    end else begin
      kept_cnt_r <= kept_cnt_nxt;
      if (cmd.clear)      counted_r <= '0;
      else if (do_count)  counted_r <= counted_r + 1'b1;
      if (cmd.rst_pos)    pos_r <= '0;
      else if (cmd.step)  pos_r <= pos_r + 1'b1;
    end
  end

  // Arrival id memory
  always_ff @(posedge clk) begin
    if (do_count) arr_mem[counted_r[IDX_W-1:0]] <= in_node_id;
    if (cmd.arr_read) rd_id_r <= arr_mem[pos_r[IDX_W-1:0]];
  end

  // Status
  assign align_sum = {1'b0, pos_r} + {1'b0, m_sel};
  assign arr_next  = {1'b0, pos_r} + 1'b1;

  assign sts.arr_mode   = (CFG_W'(counted_r) <= keep_count_r);
  assign sts.list_empty = sts.arr_mode ? (counted_r == '0) : (m_sel == '0);
  assign sts.align_done = (align_sum == (CNT_W + 1)'(MAX_NODES));
  assign sts.last_out   = sts.arr_mode ? (arr_next == {1'b0, counted_r})
                                       : (pos_r == MAX_CNT - 1'b1);

  // Result id: arrival memory, top of the chain, or zero when empty
  assign out_node_id = sts.list_empty ? '0
                     : (sts.arr_mode ? rd_id_r : ids_r[MAX_NODES-1]);

endmodule

// ----- design/k_smallest_node_selector.sv -----
// k_smallest_node_selector: top level, controller plus datapath.
// Depends on ksn_pkg, ksn_ctrl and ksn_datapath.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in_      | input     | in_valid / in_stall  | node_id, present, node_value, last_entry
//  out_     | output    | out_valid/out_stall  | node_id, empty_list, last_result
//  cfg_     | input     | cfg_we               | cfg_index, cfg_wdata (no read-back)
//
// Loading takes one transaction per cycle while in_stall is low; the insertion
// chain compares the new value against every kept cell in parallel. After
// the last entry comes a decide state, then: arrival order does a registered
// memory read, then display, per result; smallest-k order shifts the
// largest kept id to the top cell, raises out_valid, then gives one result per
// cycle while out_stall is low. An empty list shows in the cycle after decide.
// in_stall is high from the last entry until the final result is taken.
// rst_n is synchronous and active low; it clears counts and keep_count to 1.
module k_smallest_node_selector #(
  parameter int MAX_NODES  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ksn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ksn_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ksn_pkg::ID_W-1:0]      in_node_id,
  input  logic                          in_present,
  input  logic signed [VALUE_BITS-1:0]  in_node_value,
  input  logic                          in_last_entry,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ksn_pkg::ID_W-1:0]      out_node_id,
  output logic                          out_empty_list,
  output logic                          out_last_result
);
  import ksn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer
  ksn_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_entry   (in_last_entry),
    .out_stall       (out_stall),
    .sts             (sts),
    .cmd             (cmd),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_empty_list  (out_empty_list),
    .out_last_result (out_last_result)
  );

  // Storage and compare logic
  ksn_datapath #(
    .MAX_NODES  (MAX_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_node_id    (in_node_id),
    .in_present    (in_present),
    .in_node_value (in_node_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_node_id   (out_node_id)
  );

endmodule

// ----- bench/tb_k_smallest_node_selector.sv -----
`timescale 1ns / 1ps
// tb_k_smallest_node_selector: self-checking bench for the k-smallest node selector.
// Needs ksn_pkg and the design sources; runs a directed table, then random candidate lists.
module tb_k_smallest_node_selector;
  import ksn_pkg::*;

  localparam int MAX_NODES   = 64;
  localparam int VALUE_BITS  = 32;
  localparam int SETTLE      = 8;      // quiet cycles before a register write
  localparam int TAIL        = 96;     // align pass plus margin at the end
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 65;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  // how a row's result is checked: by the predictor, or typed in directly
  typedef enum logic [1:0] {EXP_MODEL, EXP_ONE, EXP_EMPTY} exp_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [CFG_IDX_W-1:0]         reg_idx;
    logic [CFG_W-1:0]             reg_val;
    logic [ID_W-1:0]              id;
    logic                         present;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
    exp_kind_t                    exp_kind;
    logic [ID_W-1:0]              exp_id;
  } row_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            empty;
    logic            last;
  } pick_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]             cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [ID_W-1:0]              in_node_id;
  logic                         in_present;
  logic signed [VALUE_BITS-1:0] in_node_value;
  logic                         in_last_entry;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ID_W-1:0]              out_node_id;
  logic                         out_empty_list;
  logic                         out_last_result;

  k_smallest_node_selector #(
    .MAX_NODES  (MAX_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_node_id      (in_node_id),
    .in_present      (in_present),
    .in_node_value   (in_node_value),
    .in_last_entry   (in_last_entry),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_id     (out_node_id),
    .out_empty_list  (out_empty_list),
    .out_last_result (out_last_result)
  );

  // Predictor state: registers, arrival list and sorted kept list
  logic [CFG_W-1:0]             keep_cfg    = KEEP_COUNT_RST;
  logic                         expand_mode = 1'b0;
  logic [ID_W-1:0]              arr_ids  [MAX_NODES];
  logic signed [VALUE_BITS-1:0] kept_val [MAX_NODES];
  logic [ID_W-1:0]              kept_id  [MAX_NODES];
  int                           n_counted = 0;
  int                           n_kept    = 0;

  pick_t new_picks [$];   // results of the latest accepted transaction
  pick_t picks_due [$];   // results still to come out of the block
  row_t  directed  [$];
  pick_t want_pick;

  int bad_picks     = 0;
  int cycles        = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void log_miss(string tag, pick_t want);
    bad_picks++;
    if (bad_picks <= 10)
      $display("%0t %s: expected id=%0d empty=%0d last=%0d, got id=%0d empty=%0d last=%0d",
                $time, tag, want.id, want.empty, want.last,
                out_node_id, out_empty_list, out_last_result);
  endfunction

  // Absorb one candidate; on the last entry, list the selection in output order
  function automatic void absorb_candidate(logic [ID_W-1:0] id, logic present,
                                           logic signed [VALUE_BITS-1:0] value,
                                           logic last);
    int    k;
    int    pos;
    int    m;
    int    i;
    logic  counts;
    logic  eligible;
    pick_t p;
    new_picks.delete();
    k = (keep_cfg > MAX_NODES) ? MAX_NODES : int'(keep_cfg);
    counts = expand_mode ? present : 1'b1;
    if (counts && n_counted < MAX_NODES) begin
      eligible = expand_mode ? 1'b1 : (id != 0 && present && value >= 0);
      arr_ids[n_counted] = id;
      n_counted++;
      if (eligible && k > 0) begin
        // a lowered keep_count trims to the smallest entries
        if (n_kept > k) n_kept = k;
        pos = 0;
        // non-strict compare: on a tie the earlier entry stays lower
        while (pos < n_kept && kept_val[pos] <= value) pos++;
        if (pos < k) begin
          if (n_kept < k) n_kept++;
          for (i = n_kept - 1; i > pos; i--) begin
            kept_val[i] = kept_val[i-1];
            kept_id[i]  = kept_id[i-1];
          end
          kept_val[pos] = value;
          kept_id[pos]  = id;
        end
      end
    end
    if (last) begin
      if (n_counted <= keep_cfg) begin
        // short list: every counted id in arrival order
        for (i = 0; i < n_counted; i++) begin
          p.id    = arr_ids[i];
          p.empty = 1'b0;
          p.last  = (i + 1 == n_counted);
          new_picks = {new_picks, p};
        end
      end else begin
        // kept list walked from the largest value down
        m = (n_kept < k) ? n_kept : k;
        for (i = 0; i < m; i++) begin
          p.id    = kept_id[m-1-i];
          p.empty = 1'b0;
          p.last  = (i + 1 == m);
          new_picks = {new_picks, p};
        end
      end
      if (new_picks.size() == 0) begin
        p.id    = '0;
        p.empty = 1'b1;
        p.last  = 1'b1;
        new_picks = {new_picks, p};
      end
      n_counted = 0;
      n_kept    = 0;
    end
  endfunction

  function automatic void add_item(logic [ID_W-1:0] id, logic present,
                                   logic signed [VALUE_BITS-1:0] value, logic last,
                                   exp_kind_t exp_kind, logic [ID_W-1:0] exp_id);
    row_t r;
    r.kind     = ROW_ITEM;
    r.reg_idx  = '0;
    r.reg_val  = '0;
    r.id       = id;
    r.present  = present;
    r.value    = value;
    r.last     = last;
    r.exp_kind = exp_kind;
    r.exp_id   = exp_id;
    directed   = {directed, r};
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    row_t r;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_val  = val;
    r.id       = '0;
    r.present  = 1'b0;
    r.value    = '0;
    r.last     = 1'b0;
    r.exp_kind = EXP_MODEL;
    r.exp_id   = '0;
    directed   = {directed, r};
  endfunction

  function automatic logic [CFG_W-1:0] pick_keep();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3, 4:    return 7'($urandom_range(2, 8));
      default: return 7'($urandom_range(9, 63));
    endcase
  endfunction

  function automatic row_t make_candidate(logic last);
    row_t r;
    r.kind     = ROW_ITEM;
    r.reg_idx  = '0;
    r.reg_val  = '0;
    r.exp_kind = EXP_MODEL;
    r.exp_id   = '0;
    r.id       = ($urandom_range(0, 99) < 15) ? 8'd0 : 8'($urandom_range(1, 255));
    r.present  = ($urandom_range(0, 99) < 85);
    r.last     = last;
    case ($urandom_range(0, 19))
      0, 1:             r.value = -1;
      2:                r.value = 32'sh7FFF_FFFF;
      3, 4, 5, 6, 7, 8: r.value = $urandom_range(0, 15);   // dense values force ties
      default:          r.value = $urandom() & 32'h7FFF_FFFF;
    endcase
    return r;
  endfunction

  // Drive one candidate and hold it until the block takes it
  task automatic send_item(input row_t r);
    pick_t typed;
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_node_id    <= r.id;
    in_present    <= r.present;
    in_node_value <= r.value;
    in_last_entry <= r.last;
    do @(posedge clk); while (in_stall);
    absorb_candidate(r.id, r.present, r.value, r.last);
    if (r.exp_kind == EXP_MODEL) begin
      foreach (new_picks[i]) picks_due = {picks_due, new_picks[i]};
    end else begin
      typed.id    = (r.exp_kind == EXP_EMPTY) ? 8'd0 : r.exp_id;
      typed.empty = (r.exp_kind == EXP_EMPTY);
      typed.last  = 1'b1;
      picks_due   = {picks_due, typed};
    end
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEEP_COUNT) keep_cfg = val;
    else expand_mode = val[0];
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (picks_due.size() == 0) begin
        want_pick = '{id: '0, empty: 1'b0, last: 1'b0};
        log_miss("result with nothing pending", want_pick);
      end else begin
        want_pick = picks_due.pop_front();
        if (out_node_id !== want_pick.id || out_empty_list !== want_pick.empty
            || out_last_result !== want_pick.last)
          log_miss("result mismatch", want_pick);
      end
    end
    out_stall <= ($urandom_range(1, 100) <= stall_pct);
  end

  initial begin : stimulus
    int   ph;
    int   len;
    int   sent;
    int   j;
    int   roll;
    row_t r;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_node_id    <= '0;
    in_present    <= 1'b0;
    in_node_value <= '0;
    in_last_entry <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: keep one, shrink rules
    add_item(8'd5, 1'b1, 10, 1'b1, EXP_ONE, 8'd5);              // list fits keep_count
    add_item(8'd0, 1'b0, -1, 1'b0, EXP_MODEL, 8'd0);            // counted, not eligible
    add_item(8'd255, 1'b1, 32'sh7FFF_FFFF, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd7, 1'b1, 0, 1'b1, EXP_MODEL, 8'd0);             // zero value wins
    add_cfg(REG_KEEP_COUNT, 7'd0);
    add_item(8'd9, 1'b1, 3, 1'b1, EXP_EMPTY, 8'd0);             // keep none: empty
    // Expand rules: absent dropped, negatives and node zero eligible
    add_cfg(REG_SELECT_MODE, 7'd1);
    add_cfg(REG_KEEP_COUNT, 7'd2);
    add_item(8'd1, 1'b0, 5, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd2, 1'b1, -1, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd3, 1'b1, 100, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd4, 1'b1, 100, 1'b0, EXP_MODEL, 8'd0);           // tie: earlier stays
    add_item(8'd0, 1'b1, 50, 1'b1, EXP_MODEL, 8'd0);
    add_item(8'd10, 1'b1, 7, 1'b0, EXP_MODEL, 8'd0);            // three-way tie
    add_item(8'd11, 1'b1, 7, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd12, 1'b1, 7, 1'b1, EXP_MODEL, 8'd0);
    add_item(8'd20, 1'b0, 9, 1'b1, EXP_EMPTY, 8'd0);            // nothing counted
    // Shrink rules, keep_count at its top
    add_cfg(REG_SELECT_MODE, 7'd0);
    add_cfg(REG_KEEP_COUNT, 7'd64);
    add_item(8'd0, 1'b0, -1, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd30, 1'b1, 1, 1'b1, EXP_MODEL, 8'd0);
    // keep_count lowered in the middle of a list
    add_cfg(REG_KEEP_COUNT, 7'd3);
    add_item(8'd40, 1'b1, 9, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd41, 1'b1, 8, 1'b0, EXP_MODEL, 8'd0);
    add_item(8'd42, 1'b1, 7, 1'b0, EXP_MODEL, 8'd0);
    add_cfg(REG_KEEP_COUNT, 7'd1);
    add_item(8'd43, 1'b1, 20, 1'b1, EXP_MODEL, 8'd0);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_reg(directed[i].reg_idx, directed[i].reg_val);
      else send_item(directed[i]);
    end

    // Random lists over four idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 76; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      write_reg(REG_KEEP_COUNT, pick_keep());
      write_reg(REG_SELECT_MODE, 7'($urandom_range(0, 1)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) write_reg(REG_SELECT_MODE, 7'($urandom_range(0, 1)));
          write_reg(REG_KEEP_COUNT, pick_keep());
        end
        roll = $urandom_range(0, 99);
        if (ph == 1 && sent == 0) len = 66;        // overflow past the list depth
        else if (roll < 85) len = $urandom_range(1, 8);
        else if (roll < 97) len = $urandom_range(9, 30);
        else len = $urandom_range(65, 70);
        for (j = 0; j < len; j++) begin
          r = make_candidate(j == len - 1);
          send_item(r);
        end
        sent += len;
      end
    end

    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (bad_picks == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- k_smallest_node_selector.f -----
design/ksn_pkg.sv
design/ksn_ctrl.sv
design/ksn_datapath.sv
design/k_smallest_node_selector.sv
bench/tb_k_smallest_node_selector.sv
